### hdl/srl_pkg.sv
// Shared types and constants for the sorted record list.
`timescale 1ns / 1ps
`default_nettype none

package srl_pkg;

  // Default list depth
  localparam int MAX_ENTRIES_DEF = 64;

  // Payload field widths
  localparam int REQ_W    = 3;
  localparam int POS_W    = 8;
  localparam int FIELD_W  = 16;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // Request kinds; codes 5..7 are no-ops
  typedef enum logic [REQ_W-1:0] {
    REQ_INS_KEY = 3'd0,
    REQ_INS_POS = 3'd1,
    REQ_REMOVE  = 3'd2,
    REQ_WRITE   = 3'd3,
    REQ_READ    = 3'd4
  } req_kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One stored record, 48 bits
  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] rate;
    logic [FIELD_W-1:0] hours;
  } rec_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_REMOVE,
    S_READ,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### hdl/srl_req_if.sv
// Request channel interface: valid/ready plus one request.
`timescale 1ns / 1ps
`default_nettype none

interface srl_req_if;
  logic                         valid;
  logic                         ready;
  logic [srl_pkg::REQ_W-1:0]    req_type;
  logic [srl_pkg::POS_W-1:0]    position;
  logic [srl_pkg::FIELD_W-1:0]  rec_id;
  logic [srl_pkg::FIELD_W-1:0]  rec_rate;
  logic [srl_pkg::FIELD_W-1:0]  rec_hours;

  modport source (
    output valid, req_type, position, rec_id, rec_rate, rec_hours,
    input  ready
  );
  modport sink (
    input  valid, req_type, position, rec_id, rec_rate, rec_hours,
    output ready
  );
endinterface

`default_nettype wire

### hdl/srl_res_if.sv
// Result channel interface: valid/ready plus one result.
`timescale 1ns / 1ps
`default_nettype none

interface srl_res_if;
  logic                          valid;
  logic                          ready;
  logic [srl_pkg::STATUS_W-1:0]  status;
  logic [srl_pkg::COUNT_W-1:0]   entry_count;
  logic [srl_pkg::FIELD_W-1:0]   out_id;
  logic [srl_pkg::FIELD_W-1:0]   out_rate;
  logic [srl_pkg::FIELD_W-1:0]   out_hours;

  modport source (
    output valid, status, entry_count, out_id, out_rate, out_hours,
    input  ready
  );
  modport sink (
    input  valid, status, entry_count, out_id, out_rate, out_hours,
    output ready
  );
endinterface

`default_nettype wire

### hdl/sorted_record_list.sv
// Sorted record list top level: record memory, walk sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none

// Bounded list of up to MAX_ENTRIES records (id, rate, hours) held in one
// synchronous memory with a registered read. One request is worked at a time.
// Inserts (by key or at a position) and removes walk the memory one entry per
// cycle, reading the next entry while writing the current one, from the start
// slot or position to the end of the list. A read, an overwrite, a rejected
// request or an unused code does not walk. The record memory has a single
// write port. Results sit in an output register, so the next request is
// taken while a result waits, and a sequencer that has finished only holds
// if that register is still occupied. Insert by key places the new record
// after all entries of equal or higher rate, searching from the head of the
// list.
module sorted_record_list #(
  parameter int MAX_ENTRIES = srl_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  srl_req_if.sink    req,
  srl_res_if.source  res
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = ((CW > srl_pkg::POS_W) ? CW : srl_pkg::POS_W) + 1;

  // Control and working registers
  srl_pkg::state_t  state, state_next;
  logic [CW-1:0]    cnt;
  logic [AW-1:0]    ptr;
  logic             found;
  srl_pkg::rec_t    carry;
  srl_pkg::status_t res_status;
  srl_pkg::rec_t    res_rec;

  // Output register
  logic                           out_valid;
  logic [srl_pkg::STATUS_W-1:0]   out_status;
  logic [srl_pkg::COUNT_W-1:0]    out_count;
  srl_pkg::rec_t                  out_rec;

  // Record memory ports
  srl_pkg::rec_t  mem [MAX_ENTRIES];
  srl_pkg::rec_t  q;
  srl_pkg::rec_t  wd;
  logic           we;
  logic [AW-1:0]  wa;
  logic [AW-1:0]  ra;

  // Request decode
  logic             accept;
  logic [LW-1:0]    pos_ext, cnt_ext, pos_m1;
  logic             pos_zero, in_range, in_range_ins, is_full;
  logic [AW-1:0]    pos_idx, pos_addr;
  srl_pkg::rec_t    new_rec;
  srl_pkg::state_t  acc_state;
  srl_pkg::status_t acc_status;
  logic [AW-1:0]    acc_ptr;
  logic             acc_found;
  logic             acc_write;

  // Walk decode
  logic ins_end, ins_hit, rem_last, out_free;

  assign accept = req.valid && req.ready;
  assign pos_ext = LW'(req.position);
  assign cnt_ext = LW'(cnt);
  assign pos_m1 = pos_ext - LW'(1);
  assign pos_zero = (req.position == '0);
  assign in_range = !pos_zero && (pos_ext <= cnt_ext);
  assign in_range_ins = !pos_zero && (pos_ext <= cnt_ext + LW'(1));
  assign is_full = (cnt_ext == LW'(MAX_ENTRIES));
  assign pos_idx = pos_m1[AW-1:0];
  assign pos_addr = pos_ext[AW-1:0];
  assign new_rec = '{id: req.rec_id, rate: req.rec_rate, hours: req.rec_hours};

  assign ins_end = (CW'(ptr) == cnt);
  assign ins_hit = found || (q.rate < carry.rate);
  assign rem_last = ((CW'(ptr) + CW'(1)) == cnt);
  assign out_free = !out_valid || res.ready;

  // What an accepted request does first
  always_comb begin
    acc_state = srl_pkg::S_DONE;
    acc_status = srl_pkg::ST_OK;
    acc_ptr = pos_idx;
    acc_found = 1'b1;
    acc_write = 1'b0;
    case (req.req_type)
      srl_pkg::REQ_INS_KEY: begin
        if (is_full) begin
          acc_status = srl_pkg::ST_FULL;
        end else begin
          acc_state = srl_pkg::S_INSERT;
          acc_ptr = '0;
          acc_found = 1'b0;
        end
      end
      srl_pkg::REQ_INS_POS: begin
        if (!in_range_ins) begin
          acc_status = srl_pkg::ST_RANGE;
        end else if (is_full) begin
          acc_status = srl_pkg::ST_FULL;
        end else begin
          acc_state = srl_pkg::S_INSERT;
        end
      end
      srl_pkg::REQ_REMOVE: begin
        if (!in_range) begin
          acc_status = srl_pkg::ST_RANGE;
        end else begin
          acc_state = srl_pkg::S_REMOVE;
        end
      end
      srl_pkg::REQ_WRITE: begin
        if (!in_range) begin
          acc_status = srl_pkg::ST_RANGE;
        end else begin
          acc_write = 1'b1;
        end
      end
      srl_pkg::REQ_READ: begin
        if (!in_range) begin
          acc_status = srl_pkg::ST_RANGE;
        end else begin
          acc_state = srl_pkg::S_READ;
        end
      end
      default: begin
        acc_status = srl_pkg::ST_OK;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      srl_pkg::S_IDLE: begin
        if (accept) begin
          state_next = acc_state;
        end
      end
      srl_pkg::S_INSERT: begin
        if (ins_end) begin
          state_next = srl_pkg::S_DONE;
        end
      end
      srl_pkg::S_REMOVE: begin
        if (rem_last) begin
          state_next = srl_pkg::S_DONE;
        end
      end
      srl_pkg::S_READ: begin
        state_next = srl_pkg::S_DONE;
      end
      srl_pkg::S_DONE: begin
        if (out_free) begin
          state_next = srl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = srl_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: handshake and memory port control
  always_comb begin
    req.ready = 1'b0;
    we = 1'b0;
    wa = ptr;
    wd = carry;
    ra = ptr;
    case (state)
      srl_pkg::S_IDLE: begin
        req.ready = 1'b1;
        we = accept && acc_write;
        wa = pos_idx;
        wd = new_rec;
        // prefetch the first entry the walk will look at
        if (req.req_type == srl_pkg::REQ_REMOVE) begin
          ra = pos_addr;
        end else if (req.req_type == srl_pkg::REQ_INS_KEY) begin
          ra = '0;
        end else begin
          ra = pos_idx;
        end
      end
      srl_pkg::S_INSERT: begin
        // write the carried record from the insertion point on
        we = ins_end || ins_hit;
        wd = carry;
        ra = ptr + AW'(1);
      end
      srl_pkg::S_REMOVE: begin
        // pull the next entry down one slot
        we = !rem_last;
        wd = q;
        ra = ptr + AW'(2);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Record memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    q <= mem[ra];
  end

  // Sequencer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srl_pkg::S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state == srl_pkg::S_INSERT && ins_end) begin
        cnt <= cnt + CW'(1);
      end else if (state == srl_pkg::S_REMOVE && rem_last) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    case (state)
      srl_pkg::S_IDLE: begin
        if (accept) begin
          ptr <= acc_ptr;
          found <= acc_found;
          carry <= new_rec;
          res_status <= acc_status;
          res_rec <= '0;
        end
      end
      srl_pkg::S_INSERT: begin
        if (!ins_end) begin
          ptr <= ptr + AW'(1);
          if (ins_hit) begin
            carry <= q;
            found <= 1'b1;
          end
        end
      end
      srl_pkg::S_REMOVE: begin
        if (!rem_last) begin
          ptr <= ptr + AW'(1);
        end
      end
      srl_pkg::S_READ: begin
        res_rec <= q;
      end
      default: begin
        ptr <= ptr;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == srl_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == srl_pkg::S_DONE && out_free) begin
      out_status <= res_status;
      out_count <= srl_pkg::COUNT_W'(cnt);
      out_rec <= res_rec;
    end
  end

  assign res.valid = out_valid;
  assign res.status = out_status;
  assign res.entry_count = out_count;
  assign res.out_id = out_rec.id;
  assign res.out_rate = out_rec.rate;
  assign res.out_hours = out_rec.hours;

endmodule

`default_nettype wire

### hdl/srl_chk.sv
// Port-level checker for the sorted record list, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module srl_chk #(
  parameter int MAX_ENTRIES = srl_pkg::MAX_ENTRIES_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           req_valid,
  input wire logic                           req_ready,
  input wire logic                           res_valid,
  input wire logic                           res_ready,
  input wire logic [srl_pkg::STATUS_W-1:0]   res_status,
  input wire logic [srl_pkg::COUNT_W-1:0]    res_entry_count,
  input wire logic [srl_pkg::FIELD_W-1:0]    res_out_id,
  input wire logic [srl_pkg::FIELD_W-1:0]    res_out_rate,
  input wire logic [srl_pkg::FIELD_W-1:0]    res_out_hours
);

  localparam logic [srl_pkg::COUNT_W-1:0] MaxCount = srl_pkg::COUNT_W'(MAX_ENTRIES);

  // One request in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  // A pending result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before transfer");

  // A full status only when the list really is full
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == srl_pkg::ST_FULL) |-> res_entry_count == MaxCount)
    else $error("full status with list not full");

  // Rejected requests return no record
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != srl_pkg::ST_OK)
      |-> (res_out_id == '0) && (res_out_rate == '0) && (res_out_hours == '0))
    else $error("record returned with error status");

  // Count never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid && (MAX_ENTRIES <= 127) |-> res_entry_count <= MaxCount)
    else $error("entry count beyond depth");

endmodule

bind sorted_record_list srl_chk #(.MAX_ENTRIES(MAX_ENTRIES)) u_srl_chk (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_status      (res.status),
  .res_entry_count (res.entry_count),
  .res_out_id      (res.out_id),
  .res_out_rate    (res.out_rate),
  .res_out_hours   (res.out_hours)
);

`default_nettype wire
